@@ sv/ert_pkg.sv @@
// shared types and constants for the euler rotate-translate block
// no dependencies; used by every module of the block by scoped name
package ert_pkg;

  localparam int COORD_WIDTH  = 32;
  localparam int FRAC_BITS    = 16;
  localparam int ANGLE_WIDTH  = 19;
  localparam int QW           = 32;   // matrix entry word, Q.30
  localparam int QFRAC        = 30;
  localparam int ZW           = 34;   // cordic working width
  localparam int CORDIC_STEPS = 30;
  localparam int STEP_W       = $clog2(CORDIC_STEPS);
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 32;

  localparam logic [CFG_IDX_W-1:0] REG_YAW     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PITCH   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROLL    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SHIFT_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SHIFT_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SHIFT_Z = 3'd5;

  localparam logic signed [ZW-1:0] PI_Q30      = 34'sd3373259426;
  localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [ZW-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [ANGLE_WIDTH-1:0] ANGLE_LIM =
    ANGLE_WIDTH'(PI_Q30 >>> (QFRAC - FRAC_BITS));
  localparam logic signed [63:0] HALF_Q30 = 64'sd536870912;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] in_x;
    logic signed [COORD_WIDTH-1:0] in_y;
    logic signed [COORD_WIDTH-1:0] in_z;
  } in_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] out_x;
    logic signed [COORD_WIDTH-1:0] out_y;
    logic signed [COORD_WIDTH-1:0] out_z;
  } out_t;

  typedef logic [2:0][ANGLE_WIDTH-1:0] ang_vec_t;
  typedef logic [2:0][COORD_WIDTH-1:0] shift_vec_t;
  typedef logic [8:0][QW-1:0]          mat_t;     // row-major, Q.30

  function automatic logic signed [ZW-1:0] atan_q30(input logic [STEP_W-1:0] i);
    logic signed [ZW-1:0] v;
    case (i)
      5'd0:    v = 34'sd843314857;
      5'd1:    v = 34'sd497837829;
      5'd2:    v = 34'sd263043837;
      5'd3:    v = 34'sd133525159;
      5'd4:    v = 34'sd67021687;
      5'd5:    v = 34'sd33543516;
      5'd6:    v = 34'sd16775851;
      5'd7:    v = 34'sd8388437;
      5'd8:    v = 34'sd4194283;
      5'd9:    v = 34'sd2097149;
      default: v = ZW'(64'sd1 <<< (QFRAC - int'(i)));
    endcase
    return v;
  endfunction

endpackage

@@ sv/ert_cordic.sv @@
// iterative rotation-mode cordic giving sine and cosine in Q.30
// depends on ert_pkg
module ert_cordic (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  logic signed [ert_pkg::ANGLE_WIDTH-1:0] angle,
  output logic                                 done,
  output logic signed [ert_pkg::QW-1:0]        sin_q,
  output logic signed [ert_pkg::QW-1:0]        cos_q
);

  logic signed [ert_pkg::ZW-1:0] x_r, y_r, z_r;
  logic signed [ert_pkg::ZW-1:0] x_nxt, y_nxt, z_nxt;
  logic [ert_pkg::STEP_W-1:0]    step_r;
  logic                          busy_r, done_r, neg_r;
  logic signed [ert_pkg::ANGLE_WIDTH-1:0] a_cl;
  logic signed [ert_pkg::ZW-1:0] z_in;

  // clamp to +-pi and scale to q.30; the fold into +-pi/2 is done when start loads z_r
  always_comb begin
    a_cl = angle;
    if (angle > ert_pkg::ANGLE_LIM) a_cl = ert_pkg::ANGLE_LIM;
    if (angle < -ert_pkg::ANGLE_LIM) a_cl = -ert_pkg::ANGLE_LIM;
    z_in = ert_pkg::ZW'(a_cl) <<< (ert_pkg::QFRAC - ert_pkg::FRAC_BITS);
  end

  always_comb begin
    if (z_r >= 0) begin
      x_nxt = x_r - (y_r >>> step_r);
      y_nxt = y_r + (x_r >>> step_r);
      z_nxt = z_r - ert_pkg::atan_q30(step_r);
    end else begin
      x_nxt = x_r + (y_r >>> step_r);
      y_nxt = y_r - (x_r >>> step_r);
      z_nxt = z_r + ert_pkg::atan_q30(step_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == ert_pkg::STEP_W'(ert_pkg::CORDIC_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r <= ert_pkg::CORDIC_GAIN;
      y_r <= '0;
      if (z_in > ert_pkg::HALF_PI_Q30) begin
        z_r   <= z_in - ert_pkg::PI_Q30;
        neg_r <= 1'b1;
      end else if (z_in < -ert_pkg::HALF_PI_Q30) begin
        z_r   <= z_in + ert_pkg::PI_Q30;
        neg_r <= 1'b1;
      end else begin
        z_r   <= z_in;
        neg_r <= 1'b0;
      end
    end else if (busy_r) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  assign done  = done_r;
  assign cos_q = neg_r ? -x_r[ert_pkg::QW-1:0] : x_r[ert_pkg::QW-1:0];
  assign sin_q = neg_r ? -y_r[ert_pkg::QW-1:0] : y_r[ert_pkg::QW-1:0];

endmodule

@@ sv/ert_matrix.sv @@
// builds the z-y-x rotation matrix from the three angles, one multiply at a time
// depends on ert_pkg and ert_cordic
module ert_matrix (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              ang_wr,
  input  ert_pkg::ang_vec_t ang,
  output ert_pkg::mat_t     mat,
  output logic              mat_ok
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_START = 2'd1;
  localparam logic [1:0] ST_WAIT  = 2'd2;
  localparam logic [1:0] ST_MUL   = 2'd3;
  localparam logic [3:0] LAST_OP  = 4'd13;

  logic [1:0] state_r;
  logic [1:0] idx_r;
  logic [3:0] op_r;
  logic       ph_r;
  logic       cd_done;
  logic signed [ert_pkg::QW-1:0] cd_sin, cd_cos;
  logic signed [ert_pkg::QW-1:0] s_r [3];
  logic signed [ert_pkg::QW-1:0] c_r [3];
  logic signed [ert_pkg::QW-1:0] spst_r, cpst_r, t_r;
  logic signed [ert_pkg::QW-1:0] op_a, op_b, rnd;
  logic signed [63:0]            prod_r, rsum;
  ert_pkg::mat_t                 mat_r;

  ert_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == ST_START),
    .angle (ang[idx_r]),
    .done  (cd_done),
    .sin_q (cd_sin),
    .cos_q (cd_cos)
  );

  // index 0 yaw (f), 1 pitch (t), 2 roll (p)
  always_comb begin
    case (op_r)
      4'd0:    begin op_a = s_r[2]; op_b = s_r[1]; end
      4'd1:    begin op_a = c_r[2]; op_b = s_r[1]; end
      4'd2:    begin op_a = c_r[1]; op_b = c_r[0]; end
      4'd3:    begin op_a = c_r[1]; op_b = s_r[0]; end
      4'd4:    begin op_a = c_r[1]; op_b = s_r[2]; end
      4'd5:    begin op_a = c_r[1]; op_b = c_r[2]; end
      4'd6:    begin op_a = spst_r; op_b = c_r[0]; end
      4'd7:    begin op_a = c_r[2]; op_b = s_r[0]; end
      4'd8:    begin op_a = spst_r; op_b = s_r[0]; end
      4'd9:    begin op_a = c_r[2]; op_b = c_r[0]; end
      4'd10:   begin op_a = cpst_r; op_b = c_r[0]; end
      4'd11:   begin op_a = s_r[2]; op_b = s_r[0]; end
      4'd12:   begin op_a = cpst_r; op_b = s_r[0]; end
      default: begin op_a = s_r[2]; op_b = c_r[0]; end
    endcase
    rsum = (prod_r + ert_pkg::HALF_Q30) >>> ert_pkg::QFRAC;
    rnd  = rsum[ert_pkg::QW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_START;
      idx_r   <= '0;
      op_r    <= '0;
      ph_r    <= 1'b0;
    end else if (ang_wr) begin
      state_r <= ST_START;
      idx_r   <= '0;
    end else begin
      unique case (state_r)
        ST_START: state_r <= ST_WAIT;
        ST_WAIT: begin
          if (cd_done) begin
            if (idx_r == 2'd2) begin
              state_r <= ST_MUL;
              op_r    <= '0;
              ph_r    <= 1'b0;
            end else begin
              idx_r   <= idx_r + 1'b1;
              state_r <= ST_START;
            end
          end
        end
        ST_MUL: begin
          ph_r <= ~ph_r;
          if (ph_r) begin
            op_r <= op_r + 1'b1;
            if (op_r == LAST_OP) state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_WAIT && cd_done) begin
      s_r[idx_r] <= cd_sin;
      c_r[idx_r] <= cd_cos;
    end
    if (state_r == ST_MUL) begin
      if (!ph_r) begin
        prod_r <= op_a * op_b;
        mat_r[2] <= -s_r[1];
      end else begin
        case (op_r)
          4'd0:  spst_r   <= rnd;
          4'd1:  cpst_r   <= rnd;
          4'd2:  mat_r[0] <= rnd;
          4'd3:  mat_r[1] <= rnd;
          4'd4:  mat_r[5] <= rnd;
          4'd5:  mat_r[8] <= rnd;
          4'd7:  mat_r[3] <= t_r - rnd;
          4'd9:  mat_r[4] <= t_r + rnd;
          4'd11: mat_r[6] <= t_r + rnd;
          4'd13: mat_r[7] <= t_r - rnd;
          default: t_r <= rnd;
        endcase
      end
    end
  end

  assign mat    = mat_r;
  assign mat_ok = (state_r == ST_IDLE);

endmodule

@@ sv/ert_xform.sv @@
// four-stage point pipeline: capture, nine products, row sums, round/shift/saturate
// depends on ert_pkg
module ert_xform (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  mat_ok,
  input  ert_pkg::mat_t         mat,
  input  ert_pkg::shift_vec_t   shift,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  ert_pkg::in_t          in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output ert_pkg::out_t         out_data
);

  localparam int CW = ert_pkg::COORD_WIDTH;
  localparam int PW = CW + ert_pkg::QW;
  localparam int AW = PW + 2;
  localparam int SW = AW - ert_pkg::QFRAC;
  localparam int RW = SW + 1;
  localparam logic signed [RW-1:0] SAT_HI = RW'((64'sd1 <<< (CW - 1)) - 1);
  localparam logic signed [RW-1:0] SAT_LO = -SAT_HI - 1;

  logic v1_r, v2_r, v3_r, v4_r;
  logic en1, en2, en3, en4;
  logic signed [CW-1:0] pt_r [3];
  logic signed [PW-1:0] p_r [9];
  logic signed [AW-1:0] acc_r [3];
  logic signed [CW-1:0] res_r [3];
  logic signed [RW-1:0] res_w [3];

  assign en4 = !v4_r || out_ready;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign in_ready = en1 && mat_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid && mat_ok;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      res_w[i] = RW'(acc_r[i] >>> ert_pkg::QFRAC) + RW'($signed(shift[i]));
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      pt_r[0] <= in_data.in_x;
      pt_r[1] <= in_data.in_y;
      pt_r[2] <= in_data.in_z;
    end
    if (en2) begin
      for (int k = 0; k < 9; k++) begin
        p_r[k] <= $signed(mat[k]) * pt_r[k % 3];
      end
    end
    if (en3) begin
      for (int i = 0; i < 3; i++) begin
        acc_r[i] <= AW'(p_r[3*i]) + AW'(p_r[3*i+1]) + AW'(p_r[3*i+2])
                    + AW'(ert_pkg::HALF_Q30);
      end
    end
    if (en4) begin
      for (int i = 0; i < 3; i++) begin
        if (res_w[i] > SAT_HI)      res_r[i] <= SAT_HI[CW-1:0];
        else if (res_w[i] < SAT_LO) res_r[i] <= SAT_LO[CW-1:0];
        else                        res_r[i] <= res_w[i][CW-1:0];
      end
    end
  end

  assign out_valid      = v4_r;
  assign out_data.out_x = res_r[0];
  assign out_data.out_y = res_r[1];
  assign out_data.out_z = res_r[2];

endmodule

@@ sv/euler_rotate_translate_point_top.sv @@
// top level of the euler z-y-x rotate and translate block
// depends on ert_pkg, ert_matrix, ert_xform
//
// usage
//   in_*  : one 3-d point per beat (valid/ready), signed q.16 coordinates
//   out_* : one transformed point per beat, p2 = t + r*p1, saturated
//   cfg_* : write-only registers: yaw, pitch, roll (q.16 radians),
//           shift x/y/z (q.16); written while no point is in flight
// throughput and pipeline
//   one point per cycle while out_ready is high and the matrix is ready;
//   registered stages: capture, products, row sums, round and saturate
// matrix rebuild
//   after reset and after every angle write the matrix is rebuilt by a
//   shared iterative cordic (thirty steps per angle) and one multiplier
//   (fourteen products, each a multiply phase then a store phase), during
//   which in_ready stays low
// stalls
//   a low out_ready holds the output; bubbles inside the pipeline still
//   close up, so input keeps flowing until every stage is full
// reset
//   synchronous active-low rst_n clears the configuration registers to
//   zero, empties the pipeline and starts a matrix rebuild
module euler_rotate_translate_point_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  ert_pkg::in_t                       in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output ert_pkg::out_t                      out_data,
  input  logic                               cfg_we,
  input  logic [ert_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ert_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  ert_pkg::ang_vec_t   ang_r;
  ert_pkg::shift_vec_t shift_r;
  ert_pkg::mat_t       mat;
  logic                mat_ok;
  logic                ang_wr;

  // angle writes force a matrix rebuild
  assign ang_wr = cfg_we && (cfg_index == ert_pkg::REG_YAW ||
                             cfg_index == ert_pkg::REG_PITCH ||
                             cfg_index == ert_pkg::REG_ROLL);

  // register file; indexes beyond the list are ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ang_r   <= '0;
      shift_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ert_pkg::REG_YAW:     ang_r[0]   <= cfg_wdata[ert_pkg::ANGLE_WIDTH-1:0];
        ert_pkg::REG_PITCH:   ang_r[1]   <= cfg_wdata[ert_pkg::ANGLE_WIDTH-1:0];
        ert_pkg::REG_ROLL:    ang_r[2]   <= cfg_wdata[ert_pkg::ANGLE_WIDTH-1:0];
        ert_pkg::REG_SHIFT_X: shift_r[0] <= cfg_wdata[ert_pkg::COORD_WIDTH-1:0];
        ert_pkg::REG_SHIFT_Y: shift_r[1] <= cfg_wdata[ert_pkg::COORD_WIDTH-1:0];
        ert_pkg::REG_SHIFT_Z: shift_r[2] <= cfg_wdata[ert_pkg::COORD_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // matrix builder sees the registered angles, from the cycle after the write
  ert_matrix u_matrix (
    .clk    (clk),
    .rst_n  (rst_n),
    .ang_wr (ang_wr),
    .ang    (ang_r),
    .mat    (mat),
    .mat_ok (mat_ok)
  );

  // per-point datapath
  ert_xform u_xform (
    .clk       (clk),
    .rst_n     (rst_n),
    .mat_ok    (mat_ok),
    .mat       (mat),
    .shift     (shift_r),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

@@ sv/ert_checker.sv @@
// port-level checks for the euler rotate-translate block, bound to the top level
// depends on ert_pkg and euler_rotate_translate_point_top
module ert_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input ert_pkg::out_t                  out_data,
  input logic                           cfg_we,
  input logic [ert_pkg::CFG_IDX_W-1:0]  cfg_index
);

  // pipeline empties on reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat shown straight after reset");

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat dropped or changed under stall");

  // an angle write blocks input while the matrix is rebuilt
  a_rebuild_block: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we && (cfg_index == ert_pkg::REG_YAW || cfg_index == ert_pkg::REG_PITCH ||
               cfg_index == ert_pkg::REG_ROLL) |=> !in_ready)
    else $error("input taken during matrix rebuild");

endmodule

bind euler_rotate_translate_point_top ert_checker u_ert_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data),
  .cfg_we    (cfg_we),
  .cfg_index (cfg_index)
);
